FILE: rtl/core/lrucd_pkg.sv
// Shared types and constants of the LRU object cache directory.
`timescale 1ns / 1ps

package lrucd_pkg;

    localparam int BYTES_W    = 20;
    localparam int KEY_PORT_W = 64;
    localparam int IDX_OUT_W  = 4;
    localparam int S_TDATA_W  = 88;
    localparam int M_TDATA_W  = 32;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [BYTES_W-1:0] MAX_BYTES_RESET = 20'd102400;

    // register index within the APB map (byte address / 4)
    localparam logic [0:0] CFG_MAX_OBJECT_BYTES = 1'b0;

    localparam logic REQ_LOOKUP = 1'b0;
    localparam logic REQ_INSERT = 1'b1;

    // running search result carried down the chain
    typedef struct packed {
        logic hit;
        logic free;
    } scan_flags_t;

    // line update broadcast to every cell
    typedef struct packed {
        logic en;
        logic fill;
    } wr_ctl_t;

endpackage

FILE: rtl/core/lrucd_cell.sv
// One directory line plus one stage of the search token that walks the chain.
`timescale 1ns / 1ps

module lrucd_cell #(
    parameter int KEY_BITS   = 64,
    parameter int STAMP_BITS = 32,
    parameter int IDX_W      = 4,
    parameter int INDEX      = 0
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [KEY_BITS-1:0]         key,
    input  logic [STAMP_BITS-1:0]       use_clock,
    input  lrucd_pkg::wr_ctl_t          wr_ctl,
    input  logic [IDX_W-1:0]            wr_idx,
    input  logic [lrucd_pkg::BYTES_W-1:0] wr_bytes,
    input  logic [STAMP_BITS-1:0]       wr_stamp,
    input  logic                        in_vld,
    input  lrucd_pkg::scan_flags_t      in_flags,
    input  logic [IDX_W-1:0]            in_hit_idx,
    input  logic [lrucd_pkg::BYTES_W-1:0] in_hit_bytes,
    input  logic [IDX_W-1:0]            in_free_idx,
    input  logic [IDX_W-1:0]            in_best_idx,
    input  logic [STAMP_BITS-1:0]       in_best_age,
    output logic                        out_vld,
    output lrucd_pkg::scan_flags_t      out_flags,
    output logic [IDX_W-1:0]            out_hit_idx,
    output logic [lrucd_pkg::BYTES_W-1:0] out_hit_bytes,
    output logic [IDX_W-1:0]            out_free_idx,
    output logic [IDX_W-1:0]            out_best_idx,
    output logic [STAMP_BITS-1:0]       out_best_age
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic                          valid_reg;
    logic [KEY_BITS-1:0]           key_reg;
    logic [lrucd_pkg::BYTES_W-1:0] bytes_reg;
    logic [STAMP_BITS-1:0]         stamp_reg;

    logic                          tok_vld_reg;
    lrucd_pkg::scan_flags_t        tok_flags_reg, tok_flags_next;
    logic [IDX_W-1:0]              tok_hit_idx_reg, tok_hit_idx_next;
    logic [lrucd_pkg::BYTES_W-1:0] tok_hit_bytes_reg, tok_hit_bytes_next;
    logic [IDX_W-1:0]              tok_free_idx_reg, tok_free_idx_next;
    logic [IDX_W-1:0]              tok_best_idx_reg, tok_best_idx_next;
    logic [STAMP_BITS-1:0]         tok_best_age_reg, tok_best_age_next;

    logic                          match;
    logic                          wr_sel;
    logic [STAMP_BITS-1:0]         age;

    assign match  = valid_reg && (key_reg == key);
    assign age    = use_clock - stamp_reg;
    assign wr_sel = wr_ctl.en && (wr_idx == MY_IDX);

    always_comb begin
        tok_flags_next     = in_flags;
        tok_hit_idx_next   = in_hit_idx;
        tok_hit_bytes_next = in_hit_bytes;
        tok_free_idx_next  = in_free_idx;
        tok_best_idx_next  = in_best_idx;
        tok_best_age_next  = in_best_age;
        // first match and first free line win
        if (!in_flags.hit && match) begin
            tok_flags_next.hit = 1'b1;
            tok_hit_idx_next   = MY_IDX;
            tok_hit_bytes_next = bytes_reg;
        end
        if (!in_flags.free && !valid_reg) begin
            tok_flags_next.free = 1'b1;
            tok_free_idx_next   = MY_IDX;
        end
        // strictly older only, so the lower line keeps a tie
        if ((INDEX == 0) || (age > in_best_age)) begin
            tok_best_idx_next = MY_IDX;
            tok_best_age_next = age;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= 1'b0;
            stamp_reg   <= '0;
            tok_vld_reg <= 1'b0;
        end else begin
            tok_vld_reg <= in_vld;
            if (wr_sel) begin
                stamp_reg <= wr_stamp;
                if (wr_ctl.fill) begin
                    valid_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_sel && wr_ctl.fill) begin
            key_reg   <= key;
            bytes_reg <= wr_bytes;
        end
        // hold the token data once it has passed
        if (in_vld) begin
            tok_flags_reg     <= tok_flags_next;
            tok_hit_idx_reg   <= tok_hit_idx_next;
            tok_hit_bytes_reg <= tok_hit_bytes_next;
            tok_free_idx_reg  <= tok_free_idx_next;
            tok_best_idx_reg  <= tok_best_idx_next;
            tok_best_age_reg  <= tok_best_age_next;
        end
    end

    assign out_vld       = tok_vld_reg;
    assign out_flags     = tok_flags_reg;
    assign out_hit_idx   = tok_hit_idx_reg;
    assign out_hit_bytes = tok_hit_bytes_reg;
    assign out_free_idx  = tok_free_idx_reg;
    assign out_best_idx  = tok_best_idx_reg;
    assign out_best_age  = tok_best_age_reg;

endmodule

FILE: rtl/core/lrucd_chain.sv
// Row of directory cells linked by the registered search token.
`timescale 1ns / 1ps

module lrucd_chain #(
    parameter int NUM_LINES  = 16,
    parameter int KEY_BITS   = 64,
    parameter int STAMP_BITS = 32,
    parameter int IDX_W      = 4
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [KEY_BITS-1:0]           key,
    input  logic [STAMP_BITS-1:0]         use_clock,
    input  lrucd_pkg::wr_ctl_t            wr_ctl,
    input  logic [IDX_W-1:0]              wr_idx,
    input  logic [lrucd_pkg::BYTES_W-1:0] wr_bytes,
    input  logic [STAMP_BITS-1:0]         wr_stamp,
    output logic                          res_vld,
    output lrucd_pkg::scan_flags_t        res_flags,
    output logic [IDX_W-1:0]              res_hit_idx,
    output logic [lrucd_pkg::BYTES_W-1:0] res_hit_bytes,
    output logic [IDX_W-1:0]              res_free_idx,
    output logic [IDX_W-1:0]              res_best_idx
);

    logic                          vld_w       [NUM_LINES+1];
    lrucd_pkg::scan_flags_t        flags_w     [NUM_LINES+1];
    logic [IDX_W-1:0]              hit_idx_w   [NUM_LINES+1];
    logic [lrucd_pkg::BYTES_W-1:0] hit_bytes_w [NUM_LINES+1];
    logic [IDX_W-1:0]              free_idx_w  [NUM_LINES+1];
    logic [IDX_W-1:0]              best_idx_w  [NUM_LINES+1];
    logic [STAMP_BITS-1:0]         best_age_w  [NUM_LINES+1];

    // empty token enters at line zero
    assign vld_w[0]       = start;
    assign flags_w[0]     = '0;
    assign hit_idx_w[0]   = '0;
    assign hit_bytes_w[0] = '0;
    assign free_idx_w[0]  = '0;
    assign best_idx_w[0]  = '0;
    assign best_age_w[0]  = '0;

    for (genvar i = 0; i < NUM_LINES; i++) begin : g_line
        lrucd_cell #(
            .KEY_BITS   (KEY_BITS),
            .STAMP_BITS (STAMP_BITS),
            .IDX_W      (IDX_W),
            .INDEX      (i)
        ) u_cell (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .key           (key),
            .use_clock     (use_clock),
            .wr_ctl        (wr_ctl),
            .wr_idx        (wr_idx),
            .wr_bytes      (wr_bytes),
            .wr_stamp      (wr_stamp),
            .in_vld        (vld_w[i]),
            .in_flags      (flags_w[i]),
            .in_hit_idx    (hit_idx_w[i]),
            .in_hit_bytes  (hit_bytes_w[i]),
            .in_free_idx   (free_idx_w[i]),
            .in_best_idx   (best_idx_w[i]),
            .in_best_age   (best_age_w[i]),
            .out_vld       (vld_w[i+1]),
            .out_flags     (flags_w[i+1]),
            .out_hit_idx   (hit_idx_w[i+1]),
            .out_hit_bytes (hit_bytes_w[i+1]),
            .out_free_idx  (free_idx_w[i+1]),
            .out_best_idx  (best_idx_w[i+1]),
            .out_best_age  (best_age_w[i+1])
        );
    end

    assign res_vld       = vld_w[NUM_LINES];
    assign res_flags     = flags_w[NUM_LINES];
    assign res_hit_idx   = hit_idx_w[NUM_LINES];
    assign res_hit_bytes = hit_bytes_w[NUM_LINES];
    assign res_free_idx  = free_idx_w[NUM_LINES];
    assign res_best_idx  = best_idx_w[NUM_LINES];

endmodule

FILE: rtl/core/lru_object_cache_directory.sv
// Top level of the LRU object cache directory: handshakes, sequencing, commit.
//
//  channel   dir  handshake                  word
//  s_        in   s_tvalid / s_tready        tuser req_type; tdata key_tag, object_bytes
//  m_        out  m_tvalid / m_tready        tdata hit, line_index, hit_bytes, stored,
//                                            replaced_valid
//  apb       in   psel / penable / pready    reg 0 max_object_bytes at byte 0
//
// One request at a time. The search token walks the row of line cells one line per
// cycle, from the start register through every cell register, and the result commits
// into the output register; only then is the next request word taken.
// Reset (aresetn low at a clock edge) clears valid bits, stamps and the use clock.
// A stalled result waits in the output register while the next request is taken;
// a second finished search waits for that register before it updates the lines.
`timescale 1ns / 1ps

module lru_object_cache_directory #(
    parameter int NUM_LINES  = 16,
    parameter int KEY_BITS   = 64,
    parameter int STAMP_BITS = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [0] req_type
    input  logic                                s_tuser,
    // [63:0] key_tag, [83:64] object_bytes, [87:84] zero
    input  logic [lrucd_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [0] hit, [4:1] line_index, [24:5] hit_bytes, [25] stored,
    // [26] replaced_valid, [31:27] zero
    output logic [lrucd_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lrucd_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [lrucd_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [lrucd_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                pready
);

    localparam int IDX_W = $clog2(NUM_LINES);
    localparam int BW    = lrucd_pkg::BYTES_W;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_COMMIT = 3'b100
    } state_t;

    state_t                 state_reg, state_next;
    logic                   start_reg;
    logic                   req_reg;
    logic [KEY_BITS-1:0]    key_reg;
    logic [BW-1:0]          bytes_reg;
    logic [STAMP_BITS-1:0]  use_clock_reg, use_clock_next;
    logic [BW-1:0]          max_bytes_reg;

    logic                   m_tvalid_reg;
    logic                   o_hit_reg, o_hit_next;
    logic [lrucd_pkg::IDX_OUT_W-1:0] o_idx_reg, o_idx_next;
    logic [BW-1:0]          o_bytes_reg, o_bytes_next;
    logic                   o_stored_reg, o_stored_next;
    logic                   o_evict_reg, o_evict_next;

    logic                   s_accept;
    logic                   cfg_write;
    logic                   slot_free;
    logic                   res_ready;
    logic                   commit;
    logic                   size_ok;
    logic [IDX_W-1:0]       tgt_idx;
    logic [IDX_W+lrucd_pkg::IDX_OUT_W-1:0] idx_wide;

    lrucd_pkg::wr_ctl_t     wr_ctl;
    logic [IDX_W-1:0]       wr_idx;

    logic                   res_vld;
    lrucd_pkg::scan_flags_t res_flags;
    logic [IDX_W-1:0]       res_hit_idx;
    logic [BW-1:0]          res_hit_bytes;
    logic [IDX_W-1:0]       res_free_idx;
    logic [IDX_W-1:0]       res_best_idx;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[2] == lrucd_pkg::CFG_MAX_OBJECT_BYTES);
    assign prdata    = (paddr[2] == lrucd_pkg::CFG_MAX_OBJECT_BYTES)
                       ? {{(lrucd_pkg::APB_DATA_W-BW){1'b0}}, max_bytes_reg} : '0;

    // ---------------- request capture ----------------
    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;

    // ---------------- commit decision ----------------
    assign slot_free = !m_tvalid_reg || m_tready;
    assign res_ready = ((state_reg == ST_SCAN) && res_vld) || (state_reg == ST_COMMIT);
    assign commit    = res_ready && slot_free;
    assign size_ok   = (bytes_reg <= max_bytes_reg);
    assign tgt_idx   = res_flags.free ? res_free_idx : res_best_idx;

    always_comb begin
        wr_ctl.en      = 1'b0;
        wr_ctl.fill    = 1'b0;
        wr_idx         = res_hit_idx;
        o_hit_next     = 1'b0;
        o_bytes_next   = '0;
        o_stored_next  = 1'b0;
        o_evict_next   = 1'b0;
        idx_wide       = '0;
        if (req_reg == lrucd_pkg::REQ_LOOKUP) begin
            if (res_flags.hit) begin
                // refresh recency of the hit line
                wr_ctl.en    = commit;
                o_hit_next   = 1'b1;
                o_bytes_next = res_hit_bytes;
                idx_wide     = {{lrucd_pkg::IDX_OUT_W{1'b0}}, res_hit_idx};
            end
        end else if (size_ok) begin
            wr_ctl.en     = commit;
            wr_ctl.fill   = 1'b1;
            wr_idx        = tgt_idx;
            o_stored_next = 1'b1;
            o_evict_next  = !res_flags.free;
            idx_wide      = {{lrucd_pkg::IDX_OUT_W{1'b0}}, tgt_idx};
        end
        o_idx_next = idx_wide[lrucd_pkg::IDX_OUT_W-1:0];
    end

    assign use_clock_next = use_clock_reg + STAMP_BITS'(1);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (res_vld) begin
                    state_next = slot_free ? ST_IDLE : ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (slot_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            start_reg     <= 1'b0;
            use_clock_reg <= '0;
            max_bytes_reg <= lrucd_pkg::MAX_BYTES_RESET;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            start_reg <= s_accept;
            if (wr_ctl.en) begin
                use_clock_reg <= use_clock_next;
            end
            if (cfg_write) begin
                max_bytes_reg <= pwdata[BW-1:0];
            end
            if (commit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            req_reg   <= s_tuser;
            key_reg   <= s_tdata[KEY_BITS-1:0];
            bytes_reg <= s_tdata[lrucd_pkg::KEY_PORT_W +: BW];
        end
        if (commit) begin
            o_hit_reg    <= o_hit_next;
            o_idx_reg    <= o_idx_next;
            o_bytes_reg  <= o_bytes_next;
            o_stored_reg <= o_stored_next;
            o_evict_reg  <= o_evict_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'b0, o_evict_reg, o_stored_reg, o_bytes_reg, o_idx_reg, o_hit_reg};

    // ---------------- line cells ----------------
    lrucd_chain #(
        .NUM_LINES  (NUM_LINES),
        .KEY_BITS   (KEY_BITS),
        .STAMP_BITS (STAMP_BITS),
        .IDX_W      (IDX_W)
    ) u_chain (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .start         (start_reg),
        .key           (key_reg),
        .use_clock     (use_clock_reg),
        .wr_ctl        (wr_ctl),
        .wr_idx        (wr_idx),
        .wr_bytes      (bytes_reg),
        .wr_stamp      (use_clock_next),
        .res_vld       (res_vld),
        .res_flags     (res_flags),
        .res_hit_idx   (res_hit_idx),
        .res_hit_bytes (res_hit_bytes),
        .res_free_idx  (res_free_idx),
        .res_best_idx  (res_best_idx)
    );

    // ---------------- checks ----------------
    a_token_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        res_vld |-> (state_reg == ST_SCAN))
        else $error("search token left the chain outside a scan");

    a_hit_xor_store: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[25]))
        else $error("result reports both a hit and a store");

    a_evict_needs_store: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[26]) |-> m_tdata[25])
        else $error("eviction reported without a store");

    a_write_only_on_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_ctl.en |-> (commit && !s_tready))
        else $error("line write outside commit");

endmodule

FILE: tb/lru_object_cache_directory_test.sv
// Self-checking testbench for the LRU object cache directory: stream requests, APB limit.
`timescale 1ns / 1ps

module lru_object_cache_directory_test;

    localparam int LINES          = 16;
    localparam int KEY_POOL_SIZE  = 24;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 40;

    typedef struct packed {
        logic                          hit;
        logic [3:0]                    line_index;
        logic [lrucd_pkg::BYTES_W-1:0] hit_bytes;
        logic                          stored;
        logic                          replaced_valid;
    } dir_result_t;

    // Mirror of the directory: predicts one result word per request word.
    class directory_scoreboard;
        bit                            slot_valid [LINES];
        logic [63:0]                   slot_tag   [LINES];
        logic [lrucd_pkg::BYTES_W-1:0] slot_size  [LINES];
        logic [31:0]                   slot_stamp [LINES];
        logic [31:0]                   use_count;
        logic [lrucd_pkg::BYTES_W-1:0] size_limit;
        dir_result_t                   pending_q[$];
        int                            errors;
        int                            n_requests, n_hits, n_misses, n_stored, n_evicted, n_rejected;

        function new();
            foreach (slot_valid[i]) begin
                slot_valid[i] = 1'b0;
                slot_stamp[i] = '0;
            end
            use_count  = '0;
            size_limit = lrucd_pkg::MAX_BYTES_RESET;
        endfunction

        function void note_request(logic req, logic [63:0] tag,
                                   logic [lrucd_pkg::BYTES_W-1:0] nbytes);
            dir_result_t res;
            int          slot;
            logic [31:0] age;
            logic [31:0] oldest;
            res  = '0;
            slot = -1;
            n_requests++;
            if (req == lrucd_pkg::REQ_LOOKUP) begin
                for (int i = 0; i < LINES; i++) begin
                    if (slot_valid[i] && slot_tag[i] == tag) begin
                        use_count     = use_count + 1;
                        slot_stamp[i] = use_count;
                        res.hit        = 1'b1;
                        res.line_index = i[3:0];
                        res.hit_bytes  = slot_size[i];
                        break;
                    end
                end
                if (res.hit) n_hits++; else n_misses++;
            end else if (nbytes > size_limit) begin
                n_rejected++;
            end else begin
                for (int i = 0; i < LINES; i++) begin
                    if (!slot_valid[i]) begin
                        slot = i;
                        break;
                    end
                end
                if (slot < 0) begin
                    // full: evict the oldest line, lowest index on a tie
                    res.replaced_valid = 1'b1;
                    oldest = '0;
                    for (int i = 0; i < LINES; i++) begin
                        age = use_count - slot_stamp[i];
                        if (i == 0 || age > oldest) begin
                            oldest = age;
                            slot   = i;
                        end
                    end
                    n_evicted++;
                end
                use_count        = use_count + 1;
                slot_tag[slot]   = tag;
                slot_size[slot]  = nbytes;
                slot_stamp[slot] = use_count;
                slot_valid[slot] = 1'b1;
                res.line_index   = slot[3:0];
                res.stored       = 1'b1;
                n_stored++;
            end
            pending_q.push_back(res);
        endfunction

        function void check_result(logic [lrucd_pkg::M_TDATA_W-1:0] word);
            dir_result_t exp;
            if (pending_q.size() == 0) begin
                $display("%0t ns: result word %h with nothing expected", $time, word);
                errors++;
                return;
            end
            exp = pending_q.pop_front();
            if (word[0] !== exp.hit) begin
                $display("%0t ns: hit expected %0b actual %0b", $time, exp.hit, word[0]);
                errors++;
            end
            if (word[4:1] !== exp.line_index) begin
                $display("%0t ns: line_index expected %0d actual %0d",
                         $time, exp.line_index, word[4:1]);
                errors++;
            end
            if (word[24:5] !== exp.hit_bytes) begin
                $display("%0t ns: hit_bytes expected %0d actual %0d",
                         $time, exp.hit_bytes, word[24:5]);
                errors++;
            end
            if (word[25] !== exp.stored) begin
                $display("%0t ns: stored expected %0b actual %0b", $time, exp.stored, word[25]);
                errors++;
            end
            if (word[26] !== exp.replaced_valid) begin
                $display("%0t ns: replaced_valid expected %0b actual %0b",
                         $time, exp.replaced_valid, word[26]);
                errors++;
            end
        endfunction
    endclass

    logic                             aclk;
    logic                             aresetn;
    logic                             s_tvalid;
    logic                             s_tready;
    logic                             s_tuser;
    logic [lrucd_pkg::S_TDATA_W-1:0]  s_tdata;
    logic                             m_tvalid;
    logic                             m_tready;
    logic [lrucd_pkg::M_TDATA_W-1:0]  m_tdata;
    logic                             psel;
    logic                             penable;
    logic                             pwrite;
    logic [lrucd_pkg::APB_ADDR_W-1:0] paddr;
    logic [lrucd_pkg::APB_DATA_W-1:0] pwdata;
    logic [lrucd_pkg::APB_DATA_W-1:0] prdata;
    logic                             pready;

    directory_scoreboard sb;
    logic [63:0]         key_pool [KEY_POOL_SIZE];
    bit                  idle_on;
    bit                  hold_results;
    int                  limit_writes;

    lru_object_cache_directory dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // mostly short gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_request(s_tuser, s_tdata[63:0], s_tdata[83:64]);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
        end
    end

    // result side: random stalls, plus one long hold on request
    initial begin
        int unsigned gap;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            gap = pick_gap();
            if (hold_results) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
                hold_results = 1'b0;
            end else if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    // end the run when no word moves for too long
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("timeout: no word accepted for %0d cycles", WATCHDOG_LIMIT);
        $display("FAIL lru_object_cache_directory");
        $finish;
    end

    task automatic send_request(input logic req, input logic [63:0] tag,
                                input logic [lrucd_pkg::BYTES_W-1:0] nbytes);
        int unsigned gap;
        gap = pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {4'b0, nbytes, tag};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_random_request();
        logic                          req;
        logic [63:0]                   tag;
        logic [lrucd_pkg::BYTES_W-1:0] nbytes;
        logic [31:0]                   pick;
        int unsigned                   r;
        req = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 9) == 0)
            tag = {$urandom, $urandom};
        else
            tag = key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
        r = $urandom_range(0, 99);
        if (r < 85)
            pick = $urandom_range(0, int'(sb.size_limit));
        else if (r < 95 && sb.size_limit != '1)
            pick = $urandom_range(int'(sb.size_limit) + 1, (1 << lrucd_pkg::BYTES_W) - 1);
        else
            pick = $urandom;
        nbytes = pick[lrucd_pkg::BYTES_W-1:0];
        send_request(req, tag, nbytes);
    endtask

    task automatic run_random(input int count);
        repeat (count) send_random_request();
    endtask

    // drop valid and hold until every expected word has come back
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [lrucd_pkg::BYTES_W-1:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {lrucd_pkg::CFG_MAX_OBJECT_BYTES, 2'b00};
        pwdata  <= {{(lrucd_pkg::APB_DATA_W - lrucd_pkg::BYTES_W){1'b0}}, value};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.size_limit = value;
        limit_writes++;
        // read back straight after the write
        @(negedge aclk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== {{(lrucd_pkg::APB_DATA_W - lrucd_pkg::BYTES_W){1'b0}}, value}) begin
            $display("%0t ns: max_object_bytes read expected %0d actual %0d",
                     $time, value, prdata);
            sb.errors++;
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial begin
        logic [63:0] fill_tag [13];
        logic [63:0] odd_tag;
        logic [31:0] pick;

        sb           = new();
        idle_on      = 1'b1;
        hold_results = 1'b0;
        limit_writes = 0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tuser  = lrucd_pkg::REQ_LOOKUP;
        s_tdata  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
        foreach (fill_tag[i]) fill_tag[i] = {$urandom, $urandom};
        odd_tag = {$urandom, $urandom};

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: reset limit, empty directory, boundaries, duplicates, eviction
        send_request(lrucd_pkg::REQ_LOOKUP, 64'h0, '0);
        send_request(lrucd_pkg::REQ_INSERT, 64'h0, '0);
        send_request(lrucd_pkg::REQ_INSERT, '1, lrucd_pkg::MAX_BYTES_RESET);
        send_request(lrucd_pkg::REQ_INSERT, odd_tag, lrucd_pkg::MAX_BYTES_RESET + 1'b1);
        send_request(lrucd_pkg::REQ_LOOKUP, 64'h0, '1);
        send_request(lrucd_pkg::REQ_LOOKUP, '1, '0);
        send_request(lrucd_pkg::REQ_LOOKUP, odd_tag, '0);
        send_request(lrucd_pkg::REQ_INSERT, '1, 20'd5);
        send_request(lrucd_pkg::REQ_LOOKUP, '1, '0);
        foreach (fill_tag[i]) begin
            pick = $urandom_range(0, 4096);
            send_request(lrucd_pkg::REQ_INSERT, fill_tag[i], pick[lrucd_pkg::BYTES_W-1:0]);
        end
        send_request(lrucd_pkg::REQ_INSERT, odd_tag, 20'd77);
        send_request(lrucd_pkg::REQ_LOOKUP, fill_tag[0], '0);
        send_request(lrucd_pkg::REQ_LOOKUP, odd_tag, '0);
        drain();

        write_limit('1);
        send_request(lrucd_pkg::REQ_INSERT, key_pool[0], '1);
        send_request(lrucd_pkg::REQ_LOOKUP, key_pool[0], '0);
        run_random(300);

        // hold results off long enough for the block to back up its input
        idle_on      = 1'b0;
        hold_results = 1'b1;
        run_random(20);
        idle_on = 1'b1;
        drain();

        write_limit(20'd1);
        run_random(150);
        drain();

        pick = $urandom_range(2, (1 << lrucd_pkg::BYTES_W) - 2);
        write_limit(pick[lrucd_pkg::BYTES_W-1:0]);
        run_random(150);
        idle_on = 1'b0;
        run_random(150);
        idle_on = 1'b1;
        drain();

        write_limit(lrucd_pkg::MAX_BYTES_RESET);
        run_random(450);
        drain();

        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("covered %0d requests: %0d hits, %0d misses, %0d stores (%0d evictions),",
                 sb.n_requests, sb.n_hits, sb.n_misses, sb.n_stored, sb.n_evicted);
        $display("%0d oversized inserts turned away, %0d size-limit settings",
                 sb.n_rejected, limit_writes);
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("PASS lru_object_cache_directory");
        end else begin
            $display("FAIL lru_object_cache_directory");
        end
        $finish;
    end

endmodule
